[src/cau_pkg.sv]
// shared types, constants and saturation helper for the complex arithmetic unit
package cau_pkg;

  localparam int PART_W = 16;
  localparam int PROD_W = 2 * PART_W;
  localparam int DEN_W  = 2 * PART_W;
  localparam int QUO_W  = PART_W + 1;
  localparam int PRE_W  = PROD_W + 2;
  localparam int REM_W  = DEN_W + QUO_W;

  localparam logic signed [PRE_W-1:0] PART_MAX = PRE_W'(32767);
  localparam logic signed [PRE_W-1:0] PART_MIN = -PRE_W'(32768);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // per-part sideband that rides alongside the divider
  typedef struct packed {
    op_t                      op;
    logic                     neg;
    logic                     dz;
    logic signed [PRE_W-1:0]  pre;
  } side_t;

  typedef struct packed {
    logic signed [PART_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat_part(input logic signed [PRE_W-1:0] v);
    sat_t s;
    s.ovf = 1'b0;
    if (v > PART_MAX) begin
      s.val = PART_W'(PART_MAX);
      s.ovf = 1'b1;
    end else if (v < PART_MIN) begin
      s.val = PART_W'(PART_MIN);
      s.ovf = 1'b1;
    end else begin
      s.val = PART_W'(v);
    end
    return s;
  endfunction

endpackage

[src/cau_div.sv]
// pipelined restoring divider, one quotient bit per stage
module cau_div
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [DEN_W+FRAC_BITS-1:0] mag,
  input  logic [DEN_W-1:0]           den,
  output logic [QUO_W-1:0]           quo,
  output logic                       big
);

  localparam int NUM_W = DEN_W + FRAC_BITS;

  logic [REM_W-1:0] rem_r [0:QUO_W];
  logic [REM_W-1:0] den_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             big_r [0:QUO_W];

  logic [REM_W-1:0] den_ext;
  assign den_ext = REM_W'(den);

  // first stage: load operands, flag a quotient too big for the result field
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(mag[NUM_W-1:0]);
      den_r[0] <= den_ext;
      quo_r[0] <= '0;
      big_r[0] <= ({1'b0, REM_W'(mag)} >= {1'b0, den_ext << QUO_W});
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    localparam int B = QUO_W - j;
    logic [REM_W:0] diff;
    assign diff = {1'b0, rem_r[j-1]} - {1'b0, den_r[j-1] << B};
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j] <= den_r[j-1];
        big_r[j] <= big_r[j-1];
        if (!diff[REM_W]) begin
          rem_r[j] <= diff[REM_W-1:0];
          quo_r[j] <= quo_r[j-1] | (QUO_W'(1) << B);
        end else begin
          rem_r[j] <= rem_r[j-1];
          quo_r[j] <= quo_r[j-1];
        end
      end
    end
  end

  assign quo = quo_r[QUO_W];
  assign big = big_r[QUO_W];

endmodule

[src/complex_arithmetic_unit.sv]
// complex add, subtract, multiply and divide on signed fixed point parts
//
//  channel | ports                                             | dir
//  input   | in_valid in_ready in_req_type in_a_* in_b_*       | in
//  result  | out_valid out_ready out_res_* out_overflow out_div_by_zero | out
//
// one beat per cycle sustained unless out_ready stalls; the depth is set by the
// one-bit-per-stage quotient pipeline (plus input, product/sum, divider load and output stages)
// all stages advance together whenever the output register is free or taken
// a stall freezes every stage, nothing is dropped or repeated
// reset clears the valid bits only
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic signed [PART_W-1:0] in_a_real,
  input  logic signed [PART_W-1:0] in_a_imag,
  input  logic signed [PART_W-1:0] in_b_real,
  input  logic signed [PART_W-1:0] in_b_imag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PART_W-1:0] out_res_real,
  output logic signed [PART_W-1:0] out_res_imag,
  output logic                     out_overflow,
  output logic                     out_div_by_zero
);

  localparam int NUM_W = DEN_W + FRAC_BITS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: operand capture
  logic                     v1_r;
  op_t                      op1_r;
  logic signed [PART_W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_t'(in_req_type);
      ar1_r <= in_a_real;
      ai1_r <= in_a_imag;
      br1_r <= in_b_real;
      bi1_r <= in_b_imag;
    end
  end

  // stage 2: products and add/sub sums
  logic                     v2_r;
  op_t                      op2_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, sq_r_r, sq_i_r;
  logic signed [PART_W:0]   s_re_r, s_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      p_rr_r <= ar1_r * br1_r;
      p_ii_r <= ai1_r * bi1_r;
      p_ir_r <= ai1_r * br1_r;
      p_ri_r <= ar1_r * bi1_r;
      sq_r_r <= br1_r * br1_r;
      sq_i_r <= bi1_r * bi1_r;
      if (op1_r == OP_SUB) begin
        s_re_r <= (PART_W+1)'(ar1_r) - (PART_W+1)'(br1_r);
        s_im_r <= (PART_W+1)'(ai1_r) - (PART_W+1)'(bi1_r);
      end else begin
        s_re_r <= (PART_W+1)'(ar1_r) + (PART_W+1)'(br1_r);
        s_im_r <= (PART_W+1)'(ai1_r) + (PART_W+1)'(bi1_r);
      end
    end
  end

  // stage 3 logic: cross sums, denominator, divider operands
  logic signed [PROD_W:0] m_re, m_im, d_re, d_im, d_re_abs, d_im_abs;
  logic [DEN_W-1:0]       den;
  logic [NUM_W-1:0]       mag_re, mag_im;
  side_t                  side_re, side_im;
  logic                   dz;

  always_comb begin
    m_re = (PROD_W+1)'(p_rr_r) - (PROD_W+1)'(p_ii_r);
    m_im = (PROD_W+1)'(p_ir_r) + (PROD_W+1)'(p_ri_r);
    d_re = (PROD_W+1)'(p_rr_r) + (PROD_W+1)'(p_ii_r);
    d_im = (PROD_W+1)'(p_ir_r) - (PROD_W+1)'(p_ri_r);
    d_re_abs = d_re[PROD_W] ? -d_re : d_re;
    d_im_abs = d_im[PROD_W] ? -d_im : d_im;
    den    = DEN_W'(sq_r_r) + DEN_W'(sq_i_r);
    mag_re = NUM_W'(d_re_abs[PROD_W-1:0]) << FRAC_BITS;
    mag_im = NUM_W'(d_im_abs[PROD_W-1:0]) << FRAC_BITS;
    dz     = (den == '0);

    side_re.op  = op2_r;
    side_im.op  = op2_r;
    side_re.neg = d_re[PROD_W];
    side_im.neg = d_im[PROD_W];
    side_re.dz  = dz;
    side_im.dz  = dz;
    unique case (op2_r)
      OP_MUL: begin
        side_re.pre = PRE_W'(m_re >>> FRAC_BITS);
        side_im.pre = PRE_W'(m_im >>> FRAC_BITS);
      end
      OP_ADD, OP_SUB: begin
        side_re.pre = PRE_W'(s_re_r);
        side_im.pre = PRE_W'(s_im_r);
      end
      default: begin
        side_re.pre = '0;
        side_im.pre = '0;
      end
    endcase
  end

  // divider lanes and matching sideband delay line
  logic [QUO_W-1:0] q_re, q_im;
  logic             big_re, big_im;

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk (clk),
    .en  (en),
    .mag (mag_re),
    .den (den),
    .quo (q_re),
    .big (big_re)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk (clk),
    .en  (en),
    .mag (mag_im),
    .den (den),
    .quo (q_im),
    .big (big_im)
  );

  logic  vd_r     [0:QUO_W];
  side_t sd_re_r  [0:QUO_W];
  side_t sd_im_r  [0:QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_re_r[0] <= side_re;
      sd_im_r[0] <= side_im;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd_re_r[k] <= sd_re_r[k-1];
        sd_im_r[k] <= sd_im_r[k-1];
      end
    end
  end

  // final stage: pick the result, saturate
  side_t                   f_re, f_im;
  logic [QUO_W:0]          qv_re, qv_im;
  logic signed [PRE_W-1:0] pre_re, pre_im;
  sat_t                    sat_re, sat_im;
  logic                    dz_f;

  always_comb begin
    f_re  = sd_re_r[QUO_W];
    f_im  = sd_im_r[QUO_W];
    qv_re = big_re ? ((QUO_W+1)'(1) << QUO_W) : (QUO_W+1)'(q_re);
    qv_im = big_im ? ((QUO_W+1)'(1) << QUO_W) : (QUO_W+1)'(q_im);
    dz_f  = 1'b0;
    if (f_re.op == OP_DIV) begin
      dz_f = f_re.dz;
      if (f_re.dz) begin
        pre_re = '0;
        pre_im = '0;
      end else begin
        pre_re = f_re.neg ? -PRE_W'(qv_re) : PRE_W'(qv_re);
        pre_im = f_im.neg ? -PRE_W'(qv_im) : PRE_W'(qv_im);
      end
    end else begin
      pre_re = f_re.pre;
      pre_im = f_im.pre;
    end
    sat_re = sat_part(pre_re);
    sat_im = sat_part(pre_im);
  end

  logic                     out_valid_r;
  logic signed [PART_W-1:0] res_re_r, res_im_r;
  logic                     ovf_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= sat_re.val;
      res_im_r <= sat_im.val;
      ovf_r    <= sat_re.ovf || sat_im.ovf;
      dz_r     <= dz_f;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_real    = res_re_r;
  assign out_res_imag    = res_im_r;
  assign out_overflow    = ovf_r;
  assign out_div_by_zero = dz_r;

  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> (out_res_real == '0 && out_res_imag == '0
      && !out_overflow))
    else $error("divide by zero beat carries nonzero result");

  a_ovf_rail : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_res_real == 16'sh7fff || out_res_real == 16'sh8000 ||
       out_res_imag == 16'sh7fff || out_res_imag == 16'sh8000))
    else $error("overflow flagged without a saturated part");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> ($stable(vd_r[QUO_W]) && $stable(v1_r)))
    else $error("pipeline moved during a stall");

endmodule
